@@ hw/rtl/prac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_pkg
// Shared types, register indexes and helpers for the point rotation block.
// ----------------------------------------------------------------------------
package prac_pkg;

    localparam int COORD_W   = 32;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 15;
    localparam int ROUND_HALF = 16384;
    localparam int MAG_W     = 15;
    localparam int ANGLE_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FINAL_W   = 40;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_X  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_Y  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_Z  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z = 3'd5;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    localparam trig_t TRIG_RESET = '{cos_v: 16'sd32767, sin_v: 16'sd0};

    // taylor term divisor (k+1)(k+2) for k = 1, 3, 5, ...
    function automatic logic [63:0] taylor_div(input logic [63:0] term, input int step);
        logic [63:0] q;
        case (step)
            0:  q = term / 6;
            1:  q = term / 20;
            2:  q = term / 42;
            3:  q = term / 72;
            4:  q = term / 110;
            5:  q = term / 156;
            6:  q = term / 210;
            7:  q = term / 272;
            8:  q = term / 342;
            9:  q = term / 420;
            10: q = term / 506;
            11: q = term / 600;
            12: q = term / 702;
            13: q = term / 812;
            14: q = term / 930;
            15: q = term / 1056;
            16: q = term / 1190;
            17: q = term / 1332;
            18: q = term / 1482;
            19: q = term / 1640;
            default: q = '0;
        endcase
        return q;
    endfunction

    // quarter-wave sine entry i of 2^index_bits, q15 magnitude
    function automatic logic [MAG_W-1:0] rom_entry(input int i, input int index_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        logic neg;
        x    = (HALF_PI_Q30 * 64'(i)) >> index_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        neg  = 1'b1;
        for (int s = 0; s < 20; s++) begin
            term = taylor_div((term * x2) >> 30, s);
            sum  = neg ? sum - $signed(term) : sum + $signed(term);
            neg  = ~neg;
        end
        if (sum < 0)
            sum = '0;
        r = (sum + 64'sd16384) >>> TRIG_FRAC;
        if (r > 64'sd32767)
            r = 64'sd32767;
        return r[MAG_W-1:0];
    endfunction

    // clamp a wide signed sum to the 32-bit coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [FINAL_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[FINAL_W-1:COORD_W-1] == '0 || v[FINAL_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else if (v[FINAL_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ hw/rtl/prac_plane_rot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prac_plane_rot
// Two-stage plane rotation: u = rnd(a*cos - b*sin), w = rnd(a*sin + b*cos),
// products in the first stage, sums and q15 rounding in the second.
// ----------------------------------------------------------------------------
module prac_plane_rot #(
    parameter int IN_W   = 33,
    parameter int PASS_W = 33
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [IN_W-1:0]   a,
    input  logic signed [IN_W-1:0]   b,
    input  prac_pkg::trig_t          trig,
    input  logic [PASS_W-1:0]        pass_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [IN_W+1:0]   u,
    output logic signed [IN_W+1:0]   w,
    output logic [PASS_W-1:0]        pass_out
);

    localparam int PROD_W = IN_W + prac_pkg::TRIG_W;
    localparam int SUM_W  = PROD_W + 1;

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      go1;
    logic                      go2;
    logic signed [PROD_W-1:0]  p_ac_reg, p_bs_reg, p_as_reg, p_bc_reg;
    logic signed [PROD_W-1:0]  p_ac_next, p_bs_next, p_as_next, p_bc_next;
    logic [PASS_W-1:0]         pass1_reg;
    logic signed [SUM_W-1:0]   sum_u, sum_w;
    logic signed [SUM_W-1:0]   rnd_u, rnd_w;
    logic signed [IN_W+1:0]    u_reg, w_reg, u_next, w_next;
    logic [PASS_W-1:0]         pass2_reg;

    assign go2      = !v2_reg || out_ready;
    assign go1      = !v1_reg || go2;
    assign in_ready = go1;

    always_comb
    begin
        p_ac_next = PROD_W'(a) * PROD_W'(trig.cos_v);
        p_bs_next = PROD_W'(b) * PROD_W'(trig.sin_v);
        p_as_next = PROD_W'(a) * PROD_W'(trig.sin_v);
        p_bc_next = PROD_W'(b) * PROD_W'(trig.cos_v);
    end

    // round half up: floor((v + 2^14) / 2^15)
    always_comb
    begin
        sum_u  = SUM_W'(p_ac_reg) - SUM_W'(p_bs_reg);
        sum_w  = SUM_W'(p_as_reg) + SUM_W'(p_bc_reg);
        rnd_u  = (sum_u + SUM_W'(prac_pkg::ROUND_HALF)) >>> prac_pkg::TRIG_FRAC;
        rnd_w  = (sum_w + SUM_W'(prac_pkg::ROUND_HALF)) >>> prac_pkg::TRIG_FRAC;
        u_next = rnd_u[IN_W+1:0];
        w_next = rnd_w[IN_W+1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (go1)
                v1_reg <= in_valid;
            if (go2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            p_ac_reg  <= p_ac_next;
            p_bs_reg  <= p_bs_next;
            p_as_reg  <= p_as_next;
            p_bc_reg  <= p_bc_next;
            pass1_reg <= pass_in;
        end
        if (go2)
        begin
            u_reg     <= u_next;
            w_reg     <= w_next;
            pass2_reg <= pass1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign u         = u_reg;
    assign w         = w_reg;
    assign pass_out  = pass2_reg;

endmodule

@@ hw/rtl/point_rotate_about_centroid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_about_centroid
// Rotates a Q16.16 point about a centroid by X, then Y, then Z binary angles.
// ----------------------------------------------------------------------------
// usage
//   s_* : one point per item, tdata = {src_z, src_y, src_x}, x in the low bits
//   m_* : one rotated point per item, tdata = {dst_z, dst_y, dst_x}, saturated
//   cfg : cfg_we / cfg_addr / cfg_wdata, 0..2 angles (full turn = 65536),
//         3..5 centroid; write only while no item is in flight
//   an angle write looks up its sine and cosine in the quarter-wave table in
//   the same cycle, so an item may follow the write directly
//   eight register stages from input accept to output valid: subtract, two
//   per axis rotation, saturating add
//   throughput: one item per cycle unless m_tready stalls, set by the per-stage valid/ready chain
//   a stalled m_tready holds the output register; earlier stages keep
//   taking items until their bubbles are filled, nothing is dropped
//   reset: pipeline empty, angles zero (cos 32767, sin 0), centroid zero
// ----------------------------------------------------------------------------
module point_rotate_about_centroid #(
    parameter int SINE_INDEX_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [95:0]                         s_tdata,   // src_x, src_y, src_z
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [95:0]                         m_tdata,   // dst_x, dst_y, dst_z
    input  logic                                cfg_we,
    input  logic [prac_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [prac_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int ROM_N  = 1 << SINE_INDEX_BITS;
    localparam int DW     = prac_pkg::DELTA_W;
    localparam int CW     = prac_pkg::COORD_W;
    localparam int FW     = prac_pkg::FINAL_W;

    // ---------------- sine table and config ----------------
    logic [prac_pkg::MAG_W-1:0] sine_rom [ROM_N+1];

    for (genvar i = 0; i <= ROM_N; i++)
    begin : g_rom
        localparam logic [prac_pkg::MAG_W-1:0] ENTRY = prac_pkg::rom_entry(i, SINE_INDEX_BITS);
        assign sine_rom[i] = ENTRY;
    end

    // lookup 0: sine of the written angle, lookup 1: its cosine
    logic [prac_pkg::ANGLE_W-1:0]       look_ang [2];
    logic signed [prac_pkg::TRIG_W-1:0] look_val [2];

    assign look_ang[0] = cfg_wdata[prac_pkg::ANGLE_W-1:0];
    assign look_ang[1] = cfg_wdata[prac_pkg::ANGLE_W-1:0] + prac_pkg::QUARTER_TURN;

    for (genvar g = 0; g < 2; g++)
    begin : g_look
        logic [1:0]                 quad;
        logic [SINE_INDEX_BITS-1:0] idx;
        logic [SINE_INDEX_BITS:0]   sel;
        logic [prac_pkg::MAG_W-1:0] mag;
        logic signed [prac_pkg::TRIG_W-1:0] mag_s;

        assign quad  = look_ang[g][prac_pkg::ANGLE_W-1 -: 2];
        assign idx   = look_ang[g][prac_pkg::ANGLE_W-3 -: SINE_INDEX_BITS];
        // odd quadrants read the table backwards
        assign sel   = quad[0] ? (SINE_INDEX_BITS+1)'(ROM_N) - {1'b0, idx} : {1'b0, idx};
        assign mag   = sine_rom[sel];
        assign mag_s = $signed({1'b0, mag});
        assign look_val[g] = quad[1] ? -mag_s : mag_s;
    end

    prac_pkg::trig_t         trig_x_reg, trig_y_reg, trig_z_reg;
    prac_pkg::trig_t         trig_next;
    logic signed [CW-1:0]    center_x_reg, center_y_reg, center_z_reg;

    assign trig_next = '{cos_v: look_val[1], sin_v: look_val[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_x_reg   <= prac_pkg::TRIG_RESET;
            trig_y_reg   <= prac_pkg::TRIG_RESET;
            trig_z_reg   <= prac_pkg::TRIG_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                prac_pkg::REG_ANGLE_X:  trig_x_reg   <= trig_next;
                prac_pkg::REG_ANGLE_Y:  trig_y_reg   <= trig_next;
                prac_pkg::REG_ANGLE_Z:  trig_z_reg   <= trig_next;
                prac_pkg::REG_CENTER_X: center_x_reg <= $signed(cfg_wdata[CW-1:0]);
                prac_pkg::REG_CENTER_Y: center_y_reg <= $signed(cfg_wdata[CW-1:0]);
                prac_pkg::REG_CENTER_Z: center_z_reg <= $signed(cfg_wdata[CW-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: subtract centroid ----------------
    logic                 v0_reg;
    logic                 go0;
    logic                 rx_in_ready;
    logic signed [DW-1:0] d_x_reg, d_y_reg, d_z_reg;
    logic signed [DW-1:0] d_x_next, d_y_next, d_z_next;

    assign go0      = !v0_reg || rx_in_ready;
    assign s_tready = go0;

    always_comb
    begin
        d_x_next = DW'($signed(s_tdata[CW-1:0]))      - DW'(center_x_reg);
        d_y_next = DW'($signed(s_tdata[2*CW-1:CW]))   - DW'(center_y_reg);
        d_z_next = DW'($signed(s_tdata[3*CW-1:2*CW])) - DW'(center_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (go0)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (go0)
        begin
            d_x_reg <= d_x_next;
            d_y_reg <= d_y_next;
            d_z_reg <= d_z_next;
        end
    end

    // ---------------- rotations ----------------
    logic                   rx_valid, ry_in_ready;
    logic signed [DW+1:0]   py, pz;
    logic [DW-1:0]          dx_pass;

    prac_plane_rot #(.IN_W(DW), .PASS_W(DW)) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_ready  (rx_in_ready),
        .a         (d_y_reg),
        .b         (d_z_reg),
        .trig      (trig_x_reg),
        .pass_in   (d_x_reg),
        .out_valid (rx_valid),
        .out_ready (ry_in_ready),
        .u         (py),
        .w         (pz),
        .pass_out  (dx_pass)
    );

    logic                   ry_valid, rz_in_ready;
    logic signed [DW+3:0]   qz, px;
    logic [DW+1:0]          py_pass;
    logic signed [DW+1:0]   dx_ext;

    assign dx_ext = (DW+2)'($signed(dx_pass));

    // a = pz, b = dx gives u = qz and w = px
    prac_plane_rot #(.IN_W(DW+2), .PASS_W(DW+2)) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_valid),
        .in_ready  (ry_in_ready),
        .a         (pz),
        .b         (dx_ext),
        .trig      (trig_y_reg),
        .pass_in   (py),
        .out_valid (ry_valid),
        .out_ready (rz_in_ready),
        .u         (qz),
        .w         (px),
        .pass_out  (py_pass)
    );

    logic                   rz_valid, go_out;
    logic signed [DW+5:0]   rx, ry;
    logic [DW+3:0]          qz_pass;
    logic signed [DW+3:0]   py_ext;

    assign py_ext = (DW+4)'($signed(py_pass));

    prac_plane_rot #(.IN_W(DW+4), .PASS_W(DW+4)) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ry_valid),
        .in_ready  (rz_in_ready),
        .a         (px),
        .b         (py_ext),
        .trig      (trig_z_reg),
        .pass_in   (qz),
        .out_valid (rz_valid),
        .out_ready (go_out),
        .u         (rx),
        .w         (ry),
        .pass_out  (qz_pass)
    );

    // ---------------- add centroid back and saturate ----------------
    logic                 out_valid_reg;
    logic signed [CW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [CW-1:0] out_x_next, out_y_next, out_z_next;
    logic signed [FW-1:0] sum_x, sum_y, sum_z;

    assign go_out = !out_valid_reg || m_tready;

    always_comb
    begin
        sum_x      = FW'(rx) + FW'(center_x_reg);
        sum_y      = FW'(ry) + FW'(center_y_reg);
        sum_z      = FW'($signed(qz_pass)) + FW'(center_z_reg);
        out_x_next = prac_pkg::sat_coord(sum_x);
        out_y_next = prac_pkg::sat_coord(sum_y);
        out_z_next = prac_pkg::sat_coord(sum_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go_out)
            out_valid_reg <= rz_valid;
    end

    always_ff @(posedge clk)
    begin
        if (go_out)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_z_reg, out_y_reg, out_x_reg};

`ifndef SYNTHESIS
    // an empty output register means every stage can move, so input is open
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input blocked while output register empty");

    // a zero angle write must give the identity pair
    a_zero_angle_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_addr == prac_pkg::REG_ANGLE_X && cfg_wdata[15:0] == 16'd0)
        |=> (trig_x_reg.cos_v == 16'sd32767 && trig_x_reg.sin_v == 16'sd0))
        else $error("zero angle did not load cos one, sin zero");

    // a held subtract stage keeps its item
    a_stage0_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v0_reg && !rx_in_ready) |=> (v0_reg && $stable(d_x_reg) && $stable(d_z_reg)))
        else $error("stalled subtract stage lost its item");

    // table magnitude never exceeds 32767, so no trig value hits the negative limit
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (trig_x_reg.cos_v != 16'sh8000 && trig_x_reg.sin_v != 16'sh8000
                    && trig_z_reg.cos_v != 16'sh8000 && trig_z_reg.sin_v != 16'sh8000))
        else $error("trig value out of q15 range");
`endif

endmodule
